// ----- hw/rtl/tblpm_pkg.sv -----
// Shared types, register indexes and reset constants for the two-button mode controller.
package tblpm_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int NOW_W = 32;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		MODE_STANDARD = 2'd0,
		MODE_ECO      = 2'd1,
		MODE_MAINT    = 2'd2,
		MODE_CONFIG   = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_LONG_PRESS = 2'd1,
		REG_START_MODE = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_idx_t;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd5000;
	localparam mode_t START_MODE_RST = MODE_STANDARD;

	typedef struct packed {
		logic  green_pressed;
		logic  red_pressed;
		mode_t op_mode;
		mode_t saved_mode;
	} flags_t;

	typedef struct packed {
		mode_t mode_out;
		logic  accepted;
		logic  mode_changed;
	} result_t;

endpackage

// ----- hw/rtl/tblpm_core.sv -----
// Combinational event evaluation: debounce, mode gating and next-state computation.
module tblpm_core #(
	parameter int TIME_BITS = tblpm_pkg::TIME_BITS_DEF
) (
	input  logic                         is_red,
	input  logic [TIME_BITS-1:0]         now,
	input  logic [tblpm_pkg::CFG_W-1:0]  debounce_ms,
	input  logic [tblpm_pkg::CFG_W-1:0]  long_press_ms,
	input  logic [TIME_BITS-1:0]         green_last,
	input  logic [TIME_BITS-1:0]         red_last,
	input  tblpm_pkg::flags_t            flags,
	output tblpm_pkg::flags_t            flags_next,
	output logic                         ok,
	output tblpm_pkg::result_t           result
);

	logic [TIME_BITS-1:0] held;
	logic                 pass;
	logic                 long_enough;
	tblpm_pkg::mode_t     new_mode;

	assign held = now - (is_red ? red_last : green_last);
	assign pass = held > TIME_BITS'(debounce_ms);
	assign long_enough = held >= TIME_BITS'(long_press_ms);

	always_comb begin
		flags_next = flags;
		new_mode = flags.op_mode;
		ok = 1'b0;
		if (!is_red) begin
			if (pass && (flags.op_mode inside {tblpm_pkg::MODE_STANDARD, tblpm_pkg::MODE_ECO})) begin
				ok = 1'b1;
				if (flags.green_pressed && long_enough) begin
					new_mode = (flags.op_mode == tblpm_pkg::MODE_STANDARD) ?
						tblpm_pkg::MODE_ECO : tblpm_pkg::MODE_STANDARD;
				end
				flags_next.green_pressed = !flags.green_pressed;
				flags_next.red_pressed = 1'b0;
			end
		end else begin
			if (pass && flags.op_mode != tblpm_pkg::MODE_CONFIG) begin
				ok = 1'b1;
				if (!flags.red_pressed) begin
					if (flags.op_mode != tblpm_pkg::MODE_MAINT) begin
						flags_next.saved_mode = flags.op_mode;
					end
				end else if (long_enough) begin
					new_mode = (flags.op_mode == tblpm_pkg::MODE_MAINT) ?
						flags.saved_mode : tblpm_pkg::MODE_MAINT;
				end
				flags_next.red_pressed = !flags.red_pressed;
				flags_next.green_pressed = 1'b0;
			end
		end
		flags_next.op_mode = new_mode;
		result.mode_out = new_mode;
		result.accepted = ok;
		result.mode_changed = new_mode != flags.op_mode;
	end

endmodule

// ----- hw/rtl/two_button_long_press_mode_control.sv -----
// Top level of the two-button long-press mode controller.
// An accepted input beat's result is in the output register in the cycle after the beat.
// Throughput: one event per cycle; input ready is high while the output register is empty
// or its result beat is taken in the same cycle, so only a held-off result stalls the input.
// The per-button state and the mode are updated by one combinational pass at the input beat.
// Reset (asynchronous, active low) restores the config registers to their defaults, clears both
// last-edge times and pressed flags, and starts in standard mode with no pending result.
module two_button_long_press_mode_control #(
	parameter int TIME_BITS = tblpm_pkg::TIME_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tblpm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tblpm_pkg::CFG_W-1:0]      cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             mode,
	input  logic [tblpm_pkg::NOW_W-1:0]      now_ms,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       mode_out,
	output logic                             accepted,
	output logic                             mode_changed
);

	logic [tblpm_pkg::CFG_W-1:0] debounce_q;
	logic [tblpm_pkg::CFG_W-1:0] long_press_q;
	logic [TIME_BITS-1:0]        green_last_q;
	logic [TIME_BITS-1:0]        red_last_q;
	logic [TIME_BITS-1:0]        now;
	tblpm_pkg::flags_t           flags_q;
	tblpm_pkg::flags_t           flags_next;
	tblpm_pkg::result_t          result;
	tblpm_pkg::result_t          result_q;
	logic                        ok;
	logic                        in_beat;
	logic                        out_valid_q;

	assign now = TIME_BITS'({{TIME_BITS{1'b0}}, now_ms});
	assign in_ready = !out_valid_q || out_ready;
	assign in_beat = in_valid && in_ready;

	tblpm_core #(
		.TIME_BITS(TIME_BITS)
	) u_core (
		.is_red       (mode),
		.now          (now),
		.debounce_ms  (debounce_q),
		.long_press_ms(long_press_q),
		.green_last   (green_last_q),
		.red_last     (red_last_q),
		.flags        (flags_q),
		.flags_next   (flags_next),
		.ok           (ok),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= tblpm_pkg::DEBOUNCE_RST;
			long_press_q <= tblpm_pkg::LONG_PRESS_RST;
			green_last_q <= '0;
			red_last_q <= '0;
			flags_q.green_pressed <= 1'b0;
			flags_q.red_pressed <= 1'b0;
			flags_q.op_mode <= tblpm_pkg::START_MODE_RST;
			flags_q.saved_mode <= tblpm_pkg::MODE_STANDARD;
			out_valid_q <= 1'b0;
		end else begin
			if (in_beat) begin
				flags_q <= flags_next;
				if (ok && !mode) begin
					green_last_q <= now;
				end
				if (ok && mode) begin
					red_last_q <= now;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (tblpm_pkg::reg_idx_t'(cfg_index))
					tblpm_pkg::REG_DEBOUNCE: begin
						debounce_q <= cfg_data;
					end
					tblpm_pkg::REG_LONG_PRESS: begin
						long_press_q <= cfg_data;
					end
					tblpm_pkg::REG_START_MODE: begin
						flags_q.op_mode <= tblpm_pkg::mode_t'(cfg_data[1:0]);
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign mode_out = result_q.mode_out;
	assign accepted = result_q.accepted;
	assign mode_changed = result_q.mode_changed;

endmodule
